/* src/shsec_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shsec_pkg
// Shared codes and elaboration-time column table for the shortened
// single-error-correcting Hamming codec.
// ---------------------------------------------------------------------------
package shsec_pkg;

  // Widest parity field the column functions support
  localparam int MAX_R = 7;

  typedef logic [MAX_R-1:0] col_t;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Column of data bit x: count down from 2^r-1, skipping weight <= 1
  function automatic col_t data_col(input int x, input int r);
    col_t pm;
    col_t v;
    int   i;
    pm = col_t'((1 << r) - 1);
    v  = pm;
    for (i = 0; i < x; i++) begin
      v = (v - col_t'(1)) & pm;
      while ($countones(v) <= 1) begin
        v = (v - col_t'(1)) & pm;
      end
    end
    return v;
  endfunction

  // Column of codeword bit pos for k data bits and r parity bits
  function automatic col_t column_at(input int pos, input int k, input int r);
    col_t c;
    if (pos >= r) begin
      c = data_col(k + r - 1 - pos, r);
    end else begin
      c = col_t'(1) << (r - 1 - pos);
    end
    return c;
  endfunction

endpackage

/* src/shortened_hamming_sec_codec_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shortened_hamming_sec_codec_top
// Systematic shortened SEC Hamming encoder/decoder, three-stage pipeline.
// ---------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | cmd, message, received_word
//  out     | out_valid/out_ready| codeword, decoded_message
//
//  One request per cycle sustained while out_ready stays high; a request
//  passes the input, syndrome and correction registers in turn before
//  out_valid rises for its result.
//  rst (synchronous) clears the stage valid bits only.
//  Each stage holds while the one after it is full and stalled; ready is
//  passed back combinationally, so a full pipe still takes a request in the
//  cycle its output request is taken.
// ---------------------------------------------------------------------------
module shortened_hamming_sec_codec_top #(
  parameter int DATA_BITS   = 11,
  parameter int PARITY_BITS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [DATA_BITS-1:0]             message,
  input  logic [DATA_BITS+PARITY_BITS-1:0] received_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [DATA_BITS+PARITY_BITS-1:0] codeword,
  output logic [DATA_BITS-1:0]             decoded_message
);
  import shsec_pkg::*;

  localparam int CODE_BITS = DATA_BITS + PARITY_BITS;
  // Distinct data columns before the count-down wraps
  localparam int PERIOD    = (1 << PARITY_BITS) - PARITY_BITS - 1;

  // Stage flow control
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1: capture; encode puts the message on top, bit 0 highest,
  // with zero parity
  logic                 cmd1;
  logic [CODE_BITS-1:0] word1;
  logic [CODE_BITS-1:0] word_in;
  logic [DATA_BITS-1:0] msg_rev;

  for (genvar x = 0; x < DATA_BITS; x++) begin : g_msg_rev
    assign msg_rev[DATA_BITS-1-x] = message[x];
  end

  assign word_in = (cmd == CMD_DECODE) ? received_word
                                       : {msg_rev, {PARITY_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      cmd1  <= cmd;
      word1 <= word_in;
    end
  end

  // Stage 2: syndrome (for encode this is the parity, rows in order)
  logic [PARITY_BITS-1:0] syn_comb;
  logic                   cmd2;
  logic [CODE_BITS-1:0]   word2;
  logic [PARITY_BITS-1:0] syn2;

  shsec_syndrome #(
    .DATA_BITS   (DATA_BITS),
    .PARITY_BITS (PARITY_BITS)
  ) u_syndrome (
    .word (word1),
    .syn  (syn_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      cmd2  <= cmd1;
      word2 <= word1;
      syn2  <= syn_comb;
    end
  end

  // Stage 3: column match and flip, or parity insertion for encode.
  // A data column repeated from a higher position never wins, so the
  // topmost match is the only one kept without a priority chain.
  logic [CODE_BITS-1:0]   flip;
  logic [CODE_BITS-1:0]   fixed;
  logic [PARITY_BITS-1:0] par_rev;
  logic [DATA_BITS-1:0]   data_out;

  for (genvar p = 0; p < CODE_BITS; p++) begin : g_match
    localparam col_t COL  = column_at(p, DATA_BITS, PARITY_BITS);
    localparam bit   SHAD = (p >= PARITY_BITS) && ((CODE_BITS - 1 - p) >= PERIOD);
    assign flip[p] = (COL[PARITY_BITS-1:0] == syn2) && !SHAD;
  end

  // Check row y lands on codeword bit R-1-y
  for (genvar y = 0; y < PARITY_BITS; y++) begin : g_par
    assign par_rev[PARITY_BITS-1-y] = syn2[y];
  end

  assign fixed = word2 ^ flip;

  // Data bit x sits at codeword bit N-1-x
  for (genvar x = 0; x < DATA_BITS; x++) begin : g_data
    assign data_out[x] = fixed[CODE_BITS-1-x];
  end

  logic [CODE_BITS-1:0] codeword_r;
  logic [DATA_BITS-1:0] decoded_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      if (cmd2 == CMD_DECODE) begin
        codeword_r <= '0;
        decoded_r  <= data_out;
      end else begin
        codeword_r <= {word2[CODE_BITS-1:PARITY_BITS], par_rev};
        decoded_r  <= '0;
      end
    end
  end

  assign out_valid       = v3;
  assign codeword        = codeword_r;
  assign decoded_message = decoded_r;

endmodule

/* src/shsec_syndrome.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shsec_syndrome
// Parity-check XOR trees: one reduction per check row over the codeword.
// ---------------------------------------------------------------------------
module shsec_syndrome #(
  parameter int DATA_BITS   = 11,
  parameter int PARITY_BITS = 4
) (
  input  logic [DATA_BITS+PARITY_BITS-1:0] word,
  output logic [PARITY_BITS-1:0]           syn
);
  import shsec_pkg::*;

  localparam int CODE_BITS = DATA_BITS + PARITY_BITS;

  logic [CODE_BITS-1:0] row_mask [PARITY_BITS];

  for (genvar p = 0; p < CODE_BITS; p++) begin : g_pos
    localparam col_t COL = column_at(p, DATA_BITS, PARITY_BITS);
    for (genvar y = 0; y < PARITY_BITS; y++) begin : g_row
      assign row_mask[y][p] = COL[y];
    end
  end

  for (genvar y = 0; y < PARITY_BITS; y++) begin : g_syn
    assign syn[y] = ^(word & row_mask[y]);
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the shortened SEC Hamming codec. A request queue
// feeds a clocked driver; a clocked monitor checks every result against an
// in-bench encoder/corrector, under varying back-pressure and source gaps.
// ---------------------------------------------------------------------------
module testbench;
  import shsec_pkg::*;

  localparam int K = 11;
  localparam int R = 4;
  localparam int N = K + R;
  localparam int RANDOM_REQUESTS = 925;
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_AT = 700;

  typedef struct packed {
    logic         cmd;
    logic [K-1:0] message;
    logic [N-1:0] received_word;
  } codec_request_t;

  typedef struct packed {
    logic [N-1:0] codeword;
    logic [K-1:0] decoded_message;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CMD_ENCODE;
  logic [K-1:0] message = '0;
  logic [N-1:0] received_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [N-1:0] codeword;
  logic [K-1:0] decoded_message;

  // Check column of each codeword position, filled at time zero
  logic [R-1:0] check_col [N];

  codec_request_t request_q[$];
  codec_result_t  result_q[$];

  int total_requests = 0;
  int sent = 0;
  int n_encode = 0;
  int n_decode = 0;
  int checked = 0;
  int mismatches = 0;
  int send_gap_pct;
  int recv_stall_pct;
  int hold_left = 0;
  bit hold_done = 1'b0;

  shortened_hamming_sec_codec_top #(
    .DATA_BITS  (K),
    .PARITY_BITS(R)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .message        (message),
    .received_word  (received_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .codeword       (codeword),
    .decoded_message(decoded_message)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --- predictor -----------------------------------------------------------

  // Systematic encode: data bit x at codeword bit N-1-x, check row y at bit R-1-y
  function automatic logic [N-1:0] hamming_encode(input logic [K-1:0] data);
    logic [N-1:0] w;
    logic [R-1:0] par;
    w   = '0;
    par = '0;
    for (int x = 0; x < K; x++) begin
      if (data[x]) begin
        w[N-1-x] = 1'b1;
        par      = par ^ check_col[N-1-x];
      end
    end
    for (int y = 0; y < R; y++) begin
      w[R-1-y] = par[y];
    end
    return w;
  endfunction

  // Syndrome, flip the topmost matching position, then strip the data bits
  function automatic logic [K-1:0] hamming_correct(input logic [N-1:0] word);
    logic [N-1:0] w;
    logic [R-1:0] syn;
    logic [K-1:0] data;
    bit           found;
    w     = word;
    syn   = '0;
    found = 1'b0;
    for (int p = 0; p < N; p++) begin
      if (w[p]) syn = syn ^ check_col[p];
    end
    if (syn != '0) begin
      for (int p = N - 1; p >= 0; p--) begin
        if (!found && check_col[p] == syn) begin
          w[p]  = ~w[p];
          found = 1'b1;
        end
      end
    end
    for (int x = 0; x < K; x++) begin
      data[x] = w[N-1-x];
    end
    return data;
  endfunction

  function automatic codec_result_t codec_predict(input codec_request_t rq);
    codec_result_t res;
    res = '0;
    if (rq.cmd == CMD_ENCODE) begin
      res.codeword = hamming_encode(rq.message);
    end else begin
      res.decoded_message = hamming_correct(rq.received_word);
    end
    return res;
  endfunction

  // --- request generation --------------------------------------------------

  // The field a command ignores still carries random bits
  task automatic queue_encode(input logic [K-1:0] data);
    codec_request_t rq;
    rq.cmd           = CMD_ENCODE;
    rq.message       = data;
    rq.received_word = N'($urandom);
    request_q.push_back(rq);
  endtask

  task automatic queue_decode(input logic [N-1:0] word);
    codec_request_t rq;
    rq.cmd           = CMD_DECODE;
    rq.message       = K'($urandom);
    rq.received_word = word;
    request_q.push_back(rq);
  endtask

  // --- source pacing -------------------------------------------------------
  // Three phases by requests taken: light source gaps with a heavy sink stall,
  // then the reverse, then both sides flat out.
  always_comb begin
    if (sent < total_requests / 3) begin
      send_gap_pct   = 15;
      recv_stall_pct = 63;
    end else if (sent < (2 * total_requests) / 3) begin
      send_gap_pct   = 63;
      recv_stall_pct = 15;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  end

  // --- driver --------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_q.push_back(codec_predict('{cmd, message, received_word}));
        sent <= sent + 1;
        if (cmd == CMD_ENCODE) n_encode <= n_encode + 1;
        else n_decode <= n_decode + 1;
      end
      // Payload must hold while a request is offered and not yet taken
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          codec_request_t rq;
          rq = request_q.pop_front();
          in_valid      <= 1'b1;
          cmd           <= rq.cmd;
          message       <= rq.message;
          received_word <= rq.received_word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --- long sink hold-off --------------------------------------------------
  // Once, in the flat-out phase, the sink stops for a fixed stretch so the
  // pipe fills and in_ready must drop while the source keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --- monitor -------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("%0t: result with nothing outstanding: codeword %h message %h",
                     $realtime, codeword, decoded_message);
          end
        end else begin
          codec_result_t want;
          want = result_q.pop_front();
          checked <= checked + 1;
          if (codeword !== want.codeword || decoded_message !== want.decoded_message) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("%0t: mismatch: codeword exp %h got %h, message exp %h got %h",
                       $realtime, want.codeword, codeword,
                       want.decoded_message, decoded_message);
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --- sequence ------------------------------------------------------------
  initial begin
    logic [R-1:0] v;
    logic [N-1:0] good;
    logic [N-1:0] word;
    int           pick;

    // Data columns count down from all-ones, skipping weight 0 and 1
    v = '1;
    for (int x = 0; x < K; x++) begin
      check_col[N-1-x] = v;
      v = v - 1'b1;
      while ($countones(v) <= 1) v = v - 1'b1;
    end
    for (int p = 0; p < R; p++) begin
      check_col[p] = R'(1) << (R - 1 - p);
    end

    // Directed: data extremes and alternating patterns
    queue_encode('0);
    queue_encode('1);
    queue_encode(K'('h555));
    queue_encode(K'('h2AA));
    queue_encode(K'(1));
    queue_encode(K'(1) << (K - 1));
    // Decode extremes, a clean word, a single error at every position, a double error
    queue_decode('0);
    queue_decode('1);
    good = hamming_encode(K'('h5A3));
    queue_decode(good);
    for (int p = 0; p < N; p++) begin
      queue_decode(good ^ (N'(1) << p));
    end
    queue_decode(good ^ N'('h4001));

    // Random: encodes, codewords with zero or one error, and raw noise
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_encode(K'($urandom));
      end else if (pick < 80) begin
        word = hamming_encode(K'($urandom));
        if ($urandom_range(0, 3) != 0) word[$urandom_range(0, N - 1)] ^= 1'b1;
        queue_decode(word);
      end else begin
        queue_decode(N'($urandom));
      end
    end
    total_requests = request_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (sent != total_requests) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d encode and %0d decode requests, including a long sink hold-off.",
             n_encode, n_decode);
    $display("Checked %0d results, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("PASS shortened_hamming_sec_codec_top");
    end else begin
      $display("FAIL shortened_hamming_sec_codec_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timed out with %0d of %0d requests sent, %0d results outstanding.",
             sent, total_requests, result_q.size());
    $display("FAIL shortened_hamming_sec_codec_top");
    $finish;
  end

endmodule

/* shortened_hamming_sec_codec_top.f */
src/shsec_pkg.sv
src/shsec_syndrome.sv
src/shortened_hamming_sec_codec_top.sv
bench/testbench.sv
